// ===== rtl/bmp_pkg.sv =====
`timescale 1ns / 1ps
package bmp_pkg;

  localparam int MAX_COLLECTORS_DEF = 64;
  localparam int COUNT_BITS_DEF     = 16;

  localparam int SLOT_W      = 6;
  localparam int PROB_W      = 16;
  localparam int CNT_PORT_W  = 16;
  localparam int LOG_W       = 24;
  localparam int ACC_W       = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [ADDR_W-3:0] REG_PRIOR_RHO = '0;

  localparam logic [PROB_W-1:0]       PRIOR_RESET = 16'd32768;
  localparam logic signed [LOG_W-1:0] LOG_HALF    = -24'sd45426;
  localparam logic signed [LOG_W-1:0] LOG_FLOOR   = 24'sh800000;
  localparam logic [15:0]             LN2_Q16     = 16'd45426;
  localparam logic [20:0]             EXP_LIMIT   = 21'd1817040;

  typedef enum logic {KIND_LOAD = 1'b0, KIND_OBS = 1'b1} kind_t;

  typedef enum logic {Q_OBS, Q_RELOAD} q_cmd_t;

  typedef struct packed {
    q_cmd_t                   cmd;
    logic                     apply;
    logic                     last;
    logic [CNT_PORT_W-1:0]    hits;
    logic [CNT_PORT_W-1:0]    misses;
    logic signed [LOG_W-1:0]  la;
    logic signed [LOG_W-1:0]  l1a;
    logic signed [LOG_W-1:0]  lb;
    logic signed [LOG_W-1:0]  l1b;
  } q_entry_t;

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_SCALE, L_DONE} l_state_t;

  typedef enum logic [2:0] {
    F_CLEAR, F_IDLE, F_LOAD, F_OBS, F_PRIOR, F_RELOAD
  } f_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ACC, B_DIFF, B_NDIV, B_TMUL, B_TDIV, B_EXP, B_FIN, B_QDIV, B_OUT
  } b_state_t;

endpackage

// ===== rtl/bmp_log_unit.sv =====
`timescale 1ns / 1ps
module bmp_log_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bmp_pkg::PROB_W:0]          operand,
  output logic                              ready,
  output logic                              done,
  output logic signed [bmp_pkg::LOG_W-1:0]  result
);
  import bmp_pkg::*;

  l_state_t                state_r, state_nxt;
  logic [4:0]              p_r;
  logic [PROB_W:0]         m_r;
  logic [15:0]             frac_r;
  logic [3:0]              step_r;
  logic signed [LOG_W-1:0] result_r;

  logic [4:0]              msb;
  logic [2*PROB_W+1:0]     sq;
  logic [PROB_W+1:0]       sq_top;
  logic [20:0]             neg;
  logic [36:0]             mag_full;

  always_comb begin
    msb = '0;
    for (int i = 0; i <= PROB_W; i++) begin
      if (operand[i]) msb = 5'(i);
    end
  end

  assign sq       = m_r * m_r;
  assign sq_top   = sq[2*PROB_W+1:16];
  assign neg      = {5'(5'd16 - p_r), 16'd0} - {5'd0, frac_r};
  assign mag_full = neg * 37'(LN2_Q16) + 37'd32768;

  always_comb begin
    state_nxt = state_r;
    ready     = 1'b0;
    done      = 1'b0;
    case (state_r)
      L_IDLE: begin
        ready = 1'b1;
        if (start) state_nxt = (operand == '0) ? L_DONE : L_SQ;
      end
      L_SQ:    if (step_r == 4'd15) state_nxt = L_SCALE;
      L_SCALE: state_nxt = L_DONE;
      L_DONE: begin
        done      = 1'b1;
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          result_r <= LOG_FLOOR;
          p_r      <= msb;
          m_r      <= operand << (5'd16 - msb);
          frac_r   <= '0;
          step_r   <= '0;
        end
      end
      L_SQ: begin
        m_r    <= sq_top[PROB_W+1] ? sq_top[PROB_W+1:1] : sq_top[PROB_W:0];
        frac_r <= {frac_r[14:0], sq_top[PROB_W+1]};
        step_r <= step_r + 4'd1;
      end
      L_SCALE: result_r <= -LOG_W'(mag_full[36:16]);
      default: ;
    endcase
  end

  assign result = result_r;

endmodule

// ===== rtl/bmp_front.sv =====
`timescale 1ns / 1ps
module bmp_front #(
  parameter int MAX_COLLECTORS = bmp_pkg::MAX_COLLECTORS_DEF,
  parameter int COUNT_BITS     = bmp_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [bmp_pkg::SLOT_W-1:0]        in_collector_slot,
  input  logic [bmp_pkg::PROB_W-1:0]        in_alpha_value,
  input  logic [bmp_pkg::PROB_W-1:0]        in_beta_value,
  input  logic                              in_params_missing,
  input  logic [bmp_pkg::CNT_PORT_W-1:0]    in_hit_count,
  input  logic [bmp_pkg::CNT_PORT_W-1:0]    in_miss_count,
  input  logic                              in_last_in_class,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmp_pkg::ADDR_W-1:0]        paddr,
  input  logic [bmp_pkg::DATA_W-1:0]        pwdata,
  output logic [bmp_pkg::DATA_W-1:0]        prdata,
  output logic                              q_push,
  output bmp_pkg::q_entry_t                 q_data,
  input  logic                              q_full,
  output logic signed [bmp_pkg::LOG_W-1:0]  prior_la,
  output logic signed [bmp_pkg::LOG_W-1:0]  prior_lb
);
  import bmp_pkg::*;

  localparam int IDX_W  = (MAX_COLLECTORS > 1) ? $clog2(MAX_COLLECTORS) : 1;
  localparam int CNT_W  = (COUNT_BITS < CNT_PORT_W) ? COUNT_BITS : CNT_PORT_W;
  localparam int WORD_W = 4 * LOG_W + 1;
  localparam logic [CNT_PORT_W-1:0] CNT_MASK = CNT_PORT_W'((64'd1 << CNT_W) - 64'd1);
  localparam logic [PROB_W:0] ONE_Q16 = 17'h10000;

  logic [WORD_W-1:0] mem [MAX_COLLECTORS];
  logic [WORD_W-1:0] rdata_r;

  f_state_t                state_r, state_nxt;
  logic [IDX_W-1:0]        clr_r, idx_r;
  logic [PROB_W-1:0]       alpha_r, beta_r, prior_r;
  logic                    miss_flag_r, last_r, slot_ok_r, pend_r, prior_pend_r;
  logic [CNT_PORT_W-1:0]   hits_r, misses_r;
  logic [1:0]              lsel_r;
  logic signed [LOG_W-1:0] la_r, l1a_r, lb_r, prior_la_r, prior_lb_r;

  logic                    accept, cfg_wr, slot_ok, mem_we, mem_re;
  logic [IDX_W-1:0]        mem_waddr;
  logic [WORD_W-1:0]       mem_wdata;
  logic [PROB_W:0]         opnd;
  logic                    log_start, log_ready, log_done;
  logic signed [LOG_W-1:0] log_result;

  assign cfg_wr   = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_PRIOR_RHO);
  assign in_stall = (state_r != F_IDLE) | cfg_wr | prior_pend_r;
  assign accept   = in_valid & ~in_stall;
  assign slot_ok  = 32'(in_collector_slot) < 32'(MAX_COLLECTORS);
  assign mem_re   = accept & (in_kind == KIND_OBS);
  assign prdata   = (paddr[ADDR_W-1:2] == REG_PRIOR_RHO) ? {16'd0, prior_r} : '0;
  assign prior_la = prior_la_r;
  assign prior_lb = prior_lb_r;

  always_comb begin
    if (state_r == F_PRIOR) begin
      opnd = lsel_r[0] ? (ONE_Q16 - {1'b0, prior_r}) : {1'b0, prior_r};
    end else begin
      case (lsel_r)
        2'd0:    opnd = {1'b0, alpha_r};
        2'd1:    opnd = ONE_Q16 - {1'b0, alpha_r};
        2'd2:    opnd = {1'b0, beta_r};
        default: opnd = ONE_Q16 - {1'b0, beta_r};
      endcase
    end
  end

  assign log_start = ((state_r == F_LOAD) || (state_r == F_PRIOR)) && !pend_r && log_ready;

  bmp_log_unit u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (log_start),
    .operand (opnd),
    .ready   (log_ready),
    .done    (log_done),
    .result  (log_result)
  );

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = {miss_flag_r, la_r, l1a_r, lb_r, log_result};
    q_push    = 1'b0;
    q_data    = '0;
    q_data.cmd = Q_OBS;
    case (state_r)
      F_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {1'b1, {(4*LOG_W){1'b0}}};
        if (clr_r == IDX_W'(MAX_COLLECTORS - 1)) state_nxt = F_IDLE;
      end
      F_IDLE: begin
        if (prior_pend_r) begin
          state_nxt = F_PRIOR;
        end else if (accept) begin
          if (in_kind == KIND_OBS) state_nxt = F_OBS;
          else if (slot_ok) state_nxt = F_LOAD;
        end
      end
      F_LOAD: begin
        if (log_done && lsel_r == 2'd3) begin
          mem_we    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      F_OBS: begin
        q_push       = !q_full;
        q_data.apply = slot_ok_r & ~rdata_r[WORD_W-1];
        q_data.last  = last_r;
        q_data.hits  = hits_r;
        q_data.misses = misses_r;
        q_data.la    = rdata_r[4*LOG_W-1:3*LOG_W];
        q_data.l1a   = rdata_r[3*LOG_W-1:2*LOG_W];
        q_data.lb    = rdata_r[2*LOG_W-1:LOG_W];
        q_data.l1b   = rdata_r[LOG_W-1:0];
        if (!q_full) state_nxt = F_IDLE;
      end
      F_PRIOR: if (log_done && lsel_r == 2'd1) state_nxt = F_RELOAD;
      F_RELOAD: begin
        q_push     = !q_full;
        q_data.cmd = Q_RELOAD;
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[IDX_W'(in_collector_slot)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_CLEAR;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      lsel_r       <= '0;
      prior_pend_r <= 1'b0;
      prior_r      <= PRIOR_RESET;
      prior_la_r   <= LOG_HALF;
      prior_lb_r   <= LOG_HALF;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr) begin
        prior_r      <= pwdata[PROB_W-1:0];
        prior_pend_r <= 1'b1;
      end else if (state_r == F_IDLE && prior_pend_r) begin
        prior_pend_r <= 1'b0;
      end
      if (state_r == F_IDLE) begin
        lsel_r <= '0;
        pend_r <= 1'b0;
      end else begin
        if (log_start) pend_r <= 1'b1;
        if (log_done) begin
          pend_r <= 1'b0;
          lsel_r <= lsel_r + 2'd1;
        end
      end
      if (log_done && state_r == F_PRIOR) begin
        if (lsel_r[0]) prior_lb_r <= log_result;
        else prior_la_r <= log_result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r       <= IDX_W'(in_collector_slot);
      alpha_r     <= in_alpha_value;
      beta_r      <= in_beta_value;
      miss_flag_r <= in_params_missing;
      hits_r      <= in_hit_count & CNT_MASK;
      misses_r    <= in_miss_count & CNT_MASK;
      last_r      <= in_last_in_class;
      slot_ok_r   <= slot_ok;
    end
    if (log_done && state_r == F_LOAD) begin
      case (lsel_r)
        2'd0:    la_r  <= log_result;
        2'd1:    l1a_r <= log_result;
        2'd2:    lb_r  <= log_result;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bmp_queue.sv =====
`timescale 1ns / 1ps
module bmp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bmp_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output bmp_pkg::q_entry_t head,
  output logic              not_empty
);
  import bmp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_entry_t         slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r;

  assign full      = (cnt_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ===== rtl/bmp_back.sv =====
`timescale 1ns / 1ps
module bmp_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  bmp_pkg::q_entry_t                 q_head,
  output logic                              q_pop,
  input  logic signed [bmp_pkg::LOG_W-1:0]  prior_la,
  input  logic signed [bmp_pkg::LOG_W-1:0]  prior_lb,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bmp_pkg::PROB_W-1:0]        out_class_posterior
);
  import bmp_pkg::*;

  localparam int PROD_W = CNT_PORT_W + LOG_W + 2;
  localparam int SUM_W  = ACC_W + 2;

  b_state_t                 state_r, state_nxt;
  logic signed [ACC_W-1:0]  acc_a_r, acc_b_r;
  logic signed [PROD_W-1:0] pa_r, pb_r;
  logic                     last_r, ge_r;
  logic [20:0]              x_r;
  logic [5:0]               n_r;
  logic [3:0]               k_r;
  logic [2:0]               cnt_r;
  logic [32:0]              t_r;
  logic [31:0]              y_r;
  logic [3:0]               rem_r;
  logic signed [34:0]       s_r;
  logic [32:0]              e_r;
  logic [33:0]              d_r;
  logic [50:0]              num_r;
  logic [4:0]               qi_r;
  logic [16:0]              q_r;
  logic                     out_valid_r;
  logic [PROB_W-1:0]        out_post_r;

  logic signed [PROD_W-1:0] pa_c, pb_c;
  logic signed [SUM_W-1:0]  sum_a, sum_b;
  logic signed [ACC_W:0]    diff;
  logic [ACC_W:0]           xa;
  logic [20:0]              nsub;
  logic [48:0]              tprod;
  logic [31:0]              yd;
  logic [3:0]               rd;
  logic [4:0]               rw;
  logic [33:0]              d_c;
  logic [50:0]              sh;
  logic                     out_load;

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = $signed({3'b000, {(ACC_W-1){1'b1}}});
    lo = $signed({3'b111, {(ACC_W-1){1'b0}}});
    if (v > hi) return hi[ACC_W-1:0];
    if (v < lo) return lo[ACC_W-1:0];
    return v[ACC_W-1:0];
  endfunction

  assign pa_c = PROD_W'($signed({1'b0, q_head.hits})) * PROD_W'($signed(q_head.la))
              + PROD_W'($signed({1'b0, q_head.misses})) * PROD_W'($signed(q_head.l1a));
  assign pb_c = PROD_W'($signed({1'b0, q_head.hits})) * PROD_W'($signed(q_head.lb))
              + PROD_W'($signed({1'b0, q_head.misses})) * PROD_W'($signed(q_head.l1b));
  assign sum_a = SUM_W'(acc_a_r) + SUM_W'(pa_r);
  assign sum_b = SUM_W'(acc_b_r) + SUM_W'(pb_r);
  assign diff  = (ACC_W+1)'(acc_a_r) - (ACC_W+1)'(acc_b_r);
  assign xa    = diff[ACC_W] ? $unsigned(-diff) : $unsigned(diff);
  assign nsub  = 21'(LN2_Q16) << cnt_r;
  assign tprod = t_r * x_r[15:0];
  assign d_c   = {1'b0, e_r} + 34'h1_0000_0000;
  assign sh    = 51'(d_r) << qi_r;

  // 8 quotient bits per cycle of y / k
  always_comb begin
    yd = y_r;
    rd = rem_r;
    rw = '0;
    for (int i = 0; i < 8; i++) begin
      rw = {rd, yd[31]};
      yd = {yd[30:0], 1'b0};
      if (rw >= {1'b0, k_r}) begin
        rd    = 4'(rw - {1'b0, k_r});
        yd[0] = 1'b1;
      end else begin
        rd = rw[3:0];
      end
    end
  end

  assign out_load = (state_r == B_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.cmd == Q_OBS) state_nxt = B_ACC;
        end
      end
      B_ACC:  state_nxt = last_r ? B_DIFF : B_IDLE;
      B_DIFF: state_nxt = (xa >= (ACC_W+1)'(EXP_LIMIT)) ? B_FIN : B_NDIV;
      B_NDIV: if (cnt_r == 3'd0) state_nxt = B_TMUL;
      B_TMUL: state_nxt = B_TDIV;
      B_TDIV: begin
        if (cnt_r[1:0] == 2'd3) state_nxt = (k_r == 4'd12) ? B_EXP : B_TMUL;
      end
      B_EXP:  state_nxt = B_FIN;
      B_FIN:  state_nxt = B_QDIV;
      B_QDIV: if (qi_r == 5'd0) state_nxt = B_OUT;
      B_OUT:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      acc_a_r     <= ACC_W'(LOG_HALF);
      acc_b_r     <= ACC_W'(LOG_HALF);
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == B_IDLE && q_valid && q_head.cmd == Q_RELOAD) begin
        acc_a_r <= ACC_W'(prior_la);
        acc_b_r <= ACC_W'(prior_lb);
      end else if (state_r == B_ACC) begin
        acc_a_r <= sat(sum_a);
        acc_b_r <= sat(sum_b);
      end else if (state_r == B_DIFF) begin
        acc_a_r <= ACC_W'(prior_la);
        acc_b_r <= ACC_W'(prior_lb);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        pa_r   <= q_head.apply ? pa_c : '0;
        pb_r   <= q_head.apply ? pb_c : '0;
        last_r <= q_head.last;
      end
      B_DIFF: begin
        ge_r  <= !diff[ACC_W];
        x_r   <= xa[20:0];
        e_r   <= '0;
        n_r   <= '0;
        cnt_r <= 3'd5;
      end
      B_NDIV: begin
        if (x_r >= nsub) begin
          x_r        <= x_r - nsub;
          n_r[cnt_r] <= 1'b1;
        end
        cnt_r <= cnt_r - 3'd1;
        t_r   <= 33'h1_0000_0000;
        s_r   <= 35'sh1_0000_0000;
        k_r   <= 4'd1;
      end
      B_TMUL: begin
        y_r   <= tprod[47:16];
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_TDIV: begin
        y_r   <= yd;
        rem_r <= rd;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r[1:0] == 2'd3) begin
          t_r <= {1'b0, yd};
          s_r <= k_r[0] ? s_r - $signed({3'b000, yd}) : s_r + $signed({3'b000, yd});
          k_r <= k_r + 4'd1;
        end
      end
      B_EXP: e_r <= s_r[34] ? '0 : 33'($unsigned(s_r) >> n_r);
      B_FIN: begin
        d_r   <= d_c;
        num_r <= (ge_r ? (51'd1 << 48) : (51'(e_r) << 16)) + 51'(d_c >> 1);
        qi_r  <= 5'd16;
        q_r   <= '0;
      end
      B_QDIV: begin
        if (num_r >= sh) begin
          num_r     <= num_r - sh;
          q_r[qi_r] <= 1'b1;
        end
        qi_r <= qi_r - 5'd1;
      end
      default: ;
    endcase
    if (out_load) out_post_r <= q_r[16] ? {PROB_W{1'b1}} : q_r[PROB_W-1:0];
  end

  assign out_valid           = out_valid_r;
  assign out_class_posterior = out_post_r;

endmodule

// ===== rtl/binary_mixture_posterior.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// in        in_valid / in_stall       kind, slot, alpha, beta, missing, hit, miss, last
// out       out_valid / out_stall     class_posterior
// cfg       psel/penable/pwrite/pready  paddr[2:0], pwdata/prdata (prior_rho at 0x0)
//
// Observation: a table read in the front, then a multiply and an accumulate in the back.
// Load: four logs (alpha, 1-alpha, beta, 1-beta) by the shared iterative log unit (16 squarings each).
// Class end: the exp series (12 terms, skipped for a large difference) and the 17-step divider.
// Prior write: two logs (rho, 1-rho) in the log unit, input stalled meanwhile.
// After reset: the table is cleared entry by entry, marking every entry missing, input stalled.
// A 4-entry queue decouples front and back; a held result stalls the front once it fills.
module binary_mixture_posterior #(
  parameter int MAX_COLLECTORS = bmp_pkg::MAX_COLLECTORS_DEF,
  parameter int COUNT_BITS     = bmp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [bmp_pkg::SLOT_W-1:0]      in_collector_slot,
  input  logic [bmp_pkg::PROB_W-1:0]      in_alpha_value,
  input  logic [bmp_pkg::PROB_W-1:0]      in_beta_value,
  input  logic                            in_params_missing,
  input  logic [bmp_pkg::CNT_PORT_W-1:0]  in_hit_count,
  input  logic [bmp_pkg::CNT_PORT_W-1:0]  in_miss_count,
  input  logic                            in_last_in_class,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bmp_pkg::PROB_W-1:0]      out_class_posterior,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bmp_pkg::ADDR_W-1:0]      paddr,
  input  logic [bmp_pkg::DATA_W-1:0]      pwdata,
  output logic [bmp_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import bmp_pkg::*;

  logic                    q_push, q_full, q_pop, q_not_empty;
  q_entry_t                q_data, q_head;
  logic signed [LOG_W-1:0] prior_la, prior_lb;

  assign pready = 1'b1;

  bmp_front #(
    .MAX_COLLECTORS (MAX_COLLECTORS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_collector_slot (in_collector_slot),
    .in_alpha_value    (in_alpha_value),
    .in_beta_value     (in_beta_value),
    .in_params_missing (in_params_missing),
    .in_hit_count      (in_hit_count),
    .in_miss_count     (in_miss_count),
    .in_last_in_class  (in_last_in_class),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .q_push            (q_push),
    .q_data            (q_data),
    .q_full            (q_full),
    .prior_la          (prior_la),
    .prior_lb          (prior_lb)
  );

  bmp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty)
  );

  bmp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_not_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .prior_la            (prior_la),
    .prior_lb            (prior_lb),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_class_posterior (out_class_posterior)
  );

endmodule

// ===== rtl/bmp_checker.sv =====
`timescale 1ns / 1ps
module bmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_class_posterior,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_class_posterior))
    else $error("held result changed");

  a_clear_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input open during clearing pass");

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=> in_stall)
    else $error("input open while prior logs recompute");

  a_obs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind |=> in_stall)
    else $error("observation not held for table read");

  a_prior_read: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=>
      prdata == {16'd0, $past(pwdata[15:0])} || paddr[2])
    else $error("prior readback mismatch");

endmodule

bind binary_mixture_posterior bmp_checker u_chk (.*);
